// ===== sv/cau_pkg.sv =====
`default_nettype none
package cau_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int VAL_BITS  = PROD_BITS + 1;
   localparam int QUO_BITS  = WORD_BITS;
   localparam int CELLS     = QUO_BITS;
   localparam int PRE_SHIFT = QUO_BITS - FRAC_BITS;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MAG = 3'd4;

   typedef logic signed [WORD_BITS-1:0] word_type;

   // one division lane: partial remainder, and dividend bits that shift out
   // at the top while quotient bits shift in at the bottom
   typedef struct packed {
      logic                 neg;
      logic                 big;
      logic [VAL_BITS-1:0]  rem;
      logic [QUO_BITS-1:0]  nq;
   } lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 dbz;
      logic [PROD_BITS-1:0] den;
      lane_type             re;
      lane_type             im;
      word_type             res_re;
      word_type             res_im;
      logic                 ovf;
   } cell_type;

   // saturate a sign and magnitude to the word; returns {overflow, word}
   function automatic logic [WORD_BITS:0] sat_word(input logic neg,
                                                   input logic [VAL_BITS-1:0] mag);
      logic [VAL_BITS-1:0] half;
      logic [VAL_BITS-1:0] twos;
      half = {{(VAL_BITS-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
      twos = ~mag + 1'b1;
      if (neg) begin
         if (mag > half) sat_word = {1'b1, 1'b1, {(WORD_BITS-1){1'b0}}};
         else sat_word = {1'b0, twos[WORD_BITS-1:0]};
      end else begin
         if (mag >= half) sat_word = {1'b1, 1'b0, {(WORD_BITS-1){1'b1}}};
         else sat_word = {1'b0, mag[WORD_BITS-1:0]};
      end
   endfunction
endpackage
`default_nettype wire

// ===== sv/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit on signed Q7.24 parts: add, subtract, multiply,
// divide and squared magnitude of a, one item per clock cycle sustained.
// Every item passes from acceptance to its result through a stage of
// 32x32 multipliers, one of exact sums, one of rounding and saturation prep,
// 32 division cells that each settle one quotient bit, and the output
// register. All operations travel the same pipeline, so results leave in
// order. The pipeline holds only when a result is ready to land in the
// output register while the previous result is still not taken.
// Products and quotients truncate toward zero; out-of-range parts saturate
// and set overflow; a zero divisor returns zero with divide_by_zero set.
`default_nettype none
module complex_arithmetic_unit_top import cau_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_operation,
   input  wire word_type   req_a_re,
   input  wire word_type   req_a_im,
   input  wire word_type   req_b_re,
   input  wire word_type   req_b_im,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output word_type        rsp_res_re,
   output word_type        rsp_res_im,
   output logic            rsp_overflow,
   output logic            rsp_divide_by_zero
);
   cell_type chain [CELLS+1];
   logic     adv;
   logic     hold_out;
   logic     rsp_valid_ff;
   word_type re_ff, im_ff, re_in, im_in;
   logic     ovf_ff, dbz_ff, ovf_in, dbz_in;
   logic [WORD_BITS:0]  sat_re, sat_im;
   logic [VAL_BITS-1:0] q_re, q_im;
   cell_type last;

   // hold the output while its item waits; stall only on a collision
   assign hold_out  = rsp_valid_ff && !rsp_ready;
   assign last      = chain[CELLS];
   assign adv       = !(hold_out && last.valid);
   assign req_ready = adv;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_op    (req_operation),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .head     (chain[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      cau_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (adv),
         .prev  (chain[i]),
         .next  (chain[i+1])
      );
   end

   // finish the quotient: force past the top when it reached 2^QUO_BITS
   always_comb begin
      q_re = last.re.big ? (VAL_BITS'(1) << QUO_BITS)
                         : {{(VAL_BITS-QUO_BITS){1'b0}}, last.re.nq};
      q_im = last.im.big ? (VAL_BITS'(1) << QUO_BITS)
                         : {{(VAL_BITS-QUO_BITS){1'b0}}, last.im.nq};
      sat_re = sat_word(last.re.neg, q_re);
      sat_im = sat_word(last.im.neg, q_im);
      if (!last.is_div) begin
         re_in  = last.res_re;
         im_in  = last.res_im;
         ovf_in = last.ovf;
         dbz_in = 1'b0;
      end else if (last.dbz) begin
         re_in  = '0;
         im_in  = '0;
         ovf_in = 1'b0;
         dbz_in = 1'b1;
      end else begin
         re_in  = sat_re[WORD_BITS-1:0];
         im_in  = sat_im[WORD_BITS-1:0];
         ovf_in = sat_re[WORD_BITS] | sat_im[WORD_BITS];
         dbz_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (!hold_out) rsp_valid_ff <= last.valid;
      if (!hold_out) begin
         re_ff  <= re_in;
         im_ff  <= im_in;
         ovf_ff <= ovf_in;
         dbz_ff <= dbz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_re         = re_ff;
   assign rsp_res_im         = im_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dbz_ff;
endmodule
`default_nettype wire

// ===== sv/cau_front.sv =====
`default_nettype none
module cau_front import cau_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       in_valid,
   input  wire logic [2:0] in_op,
   input  wire word_type   in_a_re,
   input  wire word_type   in_a_im,
   input  wire word_type   in_b_re,
   input  wire word_type   in_b_im,
   output cell_type        head
);
   // stage 1: products
   logic                        v1_ff;
   logic [2:0]                  op1_ff;
   word_type                    ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   word_type                    m0_in, m1_in;
   // stage 2: exact sums
   logic                        v2_ff;
   logic [2:0]                  op2_ff;
   logic signed [VAL_BITS-1:0]  vre_ff, vim_ff, vre_in, vim_in;
   logic [PROD_BITS-1:0]        den_ff;
   // stage 3
   cell_type                    head_ff, head_in;
   logic                        neg_re, neg_im;
   logic [VAL_BITS-1:0]         mag_re, mag_im, sh_re, sh_im;
   logic [WORD_BITS:0]          sat_re, sat_im;
   logic [VAL_BITS+PRE_SHIFT-1:0] lim;

   always_comb begin
      m0_in = (in_op == OP_MAG) ? in_a_re : in_b_re;
      m1_in = (in_op == OP_MAG) ? in_a_im : in_b_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         head_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         head_ff.valid <= head_in.valid;
      end
      if (en) begin
         op1_ff <= in_op;
         ar1_ff <= in_a_re;
         ai1_ff <= in_a_im;
         br1_ff <= in_b_re;
         bi1_ff <= in_b_im;
         p0_ff  <= in_a_re * m0_in;
         p1_ff  <= in_a_im * m1_in;
         p2_ff  <= in_a_re * in_b_im;
         p3_ff  <= in_a_im * in_b_re;
         p4_ff  <= in_b_re * in_b_re;
         p5_ff  <= in_b_im * in_b_im;
         op2_ff <= op1_ff;
         vre_ff <= vre_in;
         vim_ff <= vim_in;
         den_ff <= $unsigned(p4_ff) + $unsigned(p5_ff);
         head_ff.is_div <= head_in.is_div;
         head_ff.dbz    <= head_in.dbz;
         head_ff.den    <= head_in.den;
         head_ff.re     <= head_in.re;
         head_ff.im     <= head_in.im;
         head_ff.res_re <= head_in.res_re;
         head_ff.res_im <= head_in.res_im;
         head_ff.ovf    <= head_in.ovf;
      end
   end

   always_comb begin
      unique case (op1_ff)
         OP_ADD: begin
            vre_in = VAL_BITS'(ar1_ff) + VAL_BITS'(br1_ff);
            vim_in = VAL_BITS'(ai1_ff) + VAL_BITS'(bi1_ff);
         end
         OP_SUB: begin
            vre_in = VAL_BITS'(ar1_ff) - VAL_BITS'(br1_ff);
            vim_in = VAL_BITS'(ai1_ff) - VAL_BITS'(bi1_ff);
         end
         OP_MUL: begin
            vre_in = VAL_BITS'(p0_ff) - VAL_BITS'(p1_ff);
            vim_in = VAL_BITS'(p2_ff) + VAL_BITS'(p3_ff);
         end
         OP_DIV: begin
            vre_in = VAL_BITS'(p0_ff) + VAL_BITS'(p1_ff);
            vim_in = VAL_BITS'(p3_ff) - VAL_BITS'(p2_ff);
         end
         OP_MAG: begin
            vre_in = VAL_BITS'(p0_ff) + VAL_BITS'(p1_ff);
            vim_in = '0;
         end
         default: begin
            vre_in = '0;
            vim_in = '0;
         end
      endcase
   end

   always_comb begin
      neg_re = vre_ff[VAL_BITS-1];
      neg_im = vim_ff[VAL_BITS-1];
      mag_re = neg_re ? $unsigned(-vre_ff) : $unsigned(vre_ff);
      mag_im = neg_im ? $unsigned(-vim_ff) : $unsigned(vim_ff);
      // products truncate toward zero: shift the magnitude
      if (op2_ff == OP_MUL || op2_ff == OP_MAG) begin
         sh_re = mag_re >> FRAC_BITS;
         sh_im = mag_im >> FRAC_BITS;
      end else begin
         sh_re = mag_re;
         sh_im = mag_im;
      end
      sat_re = sat_word(neg_re, sh_re);
      sat_im = sat_word(neg_im, sh_im);
      lim = {{(VAL_BITS-PROD_BITS){1'b0}}, den_ff, {PRE_SHIFT{1'b0}}};

      head_in.valid  = v2_ff;
      head_in.is_div = (op2_ff == OP_DIV);
      head_in.dbz    = (den_ff == '0);
      head_in.den    = den_ff;
      // quotient reaches 2^QUO_BITS when the numerator is at least den << PRE_SHIFT
      head_in.re.neg = neg_re;
      head_in.re.big = {{PRE_SHIFT{1'b0}}, mag_re} >= lim;
      head_in.re.rem = mag_re >> PRE_SHIFT;
      head_in.re.nq  = {mag_re[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      head_in.im.neg = neg_im;
      head_in.im.big = {{PRE_SHIFT{1'b0}}, mag_im} >= lim;
      head_in.im.rem = mag_im >> PRE_SHIFT;
      head_in.im.nq  = {mag_im[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      if (op2_ff > OP_MAG) begin
         head_in.res_re = '0;
         head_in.res_im = '0;
         head_in.ovf    = 1'b0;
      end else begin
         head_in.res_re = sat_re[WORD_BITS-1:0];
         head_in.res_im = sat_im[WORD_BITS-1:0];
         head_in.ovf    = sat_re[WORD_BITS] | sat_im[WORD_BITS];
      end
   end

   assign head = head_ff;
endmodule
`default_nettype wire

// ===== sv/cau_div_cell.sv =====
`default_nettype none
module cau_div_cell import cau_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire cell_type prev,
   output cell_type      next
);
   cell_type cell_ff, cell_in;

   function automatic lane_type step(input lane_type l, input logic [PROD_BITS-1:0] d);
      logic [VAL_BITS-1:0] t;
      logic                ge;
      lane_type            r;
      t  = {l.rem[VAL_BITS-2:0], l.nq[QUO_BITS-1]};
      ge = t >= {1'b0, d};
      r  = l;
      r.rem = ge ? t - {1'b0, d} : t;
      r.nq  = {l.nq[QUO_BITS-2:0], ge};
      return r;
   endfunction

   always_comb begin
      cell_in    = prev;
      cell_in.re = step(prev.re, prev.den);
      cell_in.im = step(prev.im, prev.den);
   end

   always_ff @(posedge clock) begin
      if (reset) cell_ff.valid <= 1'b0;
      else if (en) cell_ff.valid <= cell_in.valid;
      if (en) begin
         cell_ff.is_div <= cell_in.is_div;
         cell_ff.dbz    <= cell_in.dbz;
         cell_ff.den    <= cell_in.den;
         cell_ff.re     <= cell_in.re;
         cell_ff.im     <= cell_in.im;
         cell_ff.res_re <= cell_in.res_re;
         cell_ff.res_im <= cell_in.res_im;
         cell_ff.ovf    <= cell_in.ovf;
      end
   end

   assign next = cell_ff;
endmodule
`default_nettype wire

// ===== sv/cau_checker.sv =====
`default_nettype none
module cau_checker import cau_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire word_type rsp_res_re,
   input wire word_type rsp_res_im,
   input wire logic     rsp_overflow,
   input wire logic     rsp_divide_by_zero
);
   localparam word_type WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_re) && $stable(rsp_res_im))
      else $error("result changed while stalled");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("zero divisor gave nonzero result");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_divide_by_zero && rsp_overflow))
      else $error("both flags set");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_res_re == WMAX || rsp_res_re == WMIN ||
         rsp_res_im == WMAX || rsp_res_im == WMIN)
      else $error("overflow without a clamped part");
endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_res_re         (rsp_res_re),
   .rsp_res_im         (rsp_res_im),
   .rsp_overflow       (rsp_overflow),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);
`default_nettype wire
